@@ src/umrt_pkg.sv @@
// umrt_pkg: shared types and codes for the unacked message retransmit table
// depends on nothing; used by unacked_message_retransmit_table
`default_nettype none

package umrt_pkg;

  // input opcodes (in_tuser)
  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // result kinds (out_tuser)
  localparam logic [2:0] KIND_SENT    = 3'd0;
  localparam logic [2:0] KIND_DROPPED = 3'd1;
  localparam logic [2:0] KIND_ACKED   = 3'd2;
  localparam logic [2:0] KIND_NO_ACK  = 3'd3;
  localparam logic [2:0] KIND_RETX    = 3'd4;

  // configuration register indexes
  localparam logic CFG_TIMEOUT  = 1'b0;
  localparam logic CFG_INTERVAL = 1'b1;

  localparam int ID_W  = 16;
  localparam int AGE_W = 8;
  localparam logic [AGE_W-1:0] AGE_MAX = 8'd255;

  typedef struct packed {
    logic [2:0]      kind;
    logic [3:0]      slot;
    logic [ID_W-1:0] msg_id;
    logic [31:0]     tx;
    logic [4:0]      pend;
  } res_t;

endpackage

`default_nettype wire

@@ src/unacked_message_retransmit_table.sv @@
// unacked_message_retransmit_table: slot table of unacknowledged message ids with ageing
// and periodic retransmission scans; depends on umrt_pkg
// a send result goes to the hold register, then the output register; an ack scans slots
// up to a match or the last slot; a tick scans every slot, one slot read from the id/age
// memory per cycle while no retransmit waits on an output stall; throughput: one input
// transaction at a time, next one taken once the last result has moved into the output register
// reset (rst_n, synchronous): valid bits, counters and scan phase cleared, registers at
// defaults; id/age memory is not cleared, entries are only read behind a valid bit
`default_nettype none

module unacked_message_retransmit_table #(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] ack_id
  input  wire logic [1:0]  in_tuser,   // [1:0] opcode
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [3:0] slot, [19:4] message_id,
                                       // [51:20] transmissions, [56:52] pending, rest zero
  output logic [2:0]       out_tuser,  // [2:0] kind
  output logic             out_tlast,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam int EW = umrt_pkg::ID_W + umrt_pkg::AGE_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ACK   = 2'd1;
  localparam logic [1:0] ST_TICK  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  // control registers
  logic [1:0]       state_r, state_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [PW-1:0]    pend_r, pend_nxt;
  logic [15:0]      next_id_r, next_id_nxt;
  logic [31:0]      tx_r, tx_nxt;
  logic [7:0]       phase_r, phase_nxt;
  logic             scan_r, scan_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic             out_v_r, out_v_nxt;
  logic [7:0]       timeout_r, interval_r;

  // payload registers
  logic [15:0]      ack_id_r, ack_id_nxt;
  umrt_pkg::res_t   hold_r, hold_nxt;
  umrt_pkg::res_t   out_r;
  logic             out_last_r;

  // id/age memory, one write and one registered read per cycle
  logic [EW-1:0]    mem [SLOTS];
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [EW-1:0]    mem_wdata;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic [EW-1:0]    rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  logic [15:0] rd_id;
  logic [7:0]  rd_age;
  assign rd_id  = rdata_r[EW-1:umrt_pkg::AGE_W];
  assign rd_age = rdata_r[umrt_pkg::AGE_W-1:0];

  // lowest free slot
  logic          free_found;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  logic out_free;
  assign out_free = !out_v_r || out_tready;

  // scan interval of zero behaves as one
  logic [8:0] interval_eff, phase_inc;
  assign interval_eff = (interval_r == 8'd0) ? 9'd1 : {1'b0, interval_r};
  assign phase_inc    = {1'b0, phase_r} + 9'd1;

  // tick sweep: saturating age and timeout check for the slot in rdata_r
  logic [7:0] age_inc;
  logic       cur_valid, tick_hit, ack_hit;
  assign cur_valid = valid_r[idx_r];
  assign age_inc   = (rd_age == umrt_pkg::AGE_MAX) ? rd_age : rd_age + 8'd1;
  assign tick_hit  = cur_valid && scan_r && (age_inc > timeout_r);
  assign ack_hit   = cur_valid && (rd_id == ack_id_r);

  // moving a result out of the hold register
  logic           out_load, out_load_last;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    valid_nxt     = valid_r;
    pend_nxt      = pend_r;
    next_id_nxt   = next_id_r;
    tx_nxt        = tx_r;
    phase_nxt     = phase_r;
    scan_nxt      = scan_r;
    hold_v_nxt    = hold_v_r;
    hold_nxt      = hold_r;
    ack_id_nxt    = ack_id_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = rdata_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    out_load      = 1'b0;
    out_load_last = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (in_tuser)
            umrt_pkg::OP_SEND: begin
              // the id is consumed and the frame counted even when the table is full
              next_id_nxt = next_id_r + 16'd1;
              tx_nxt      = tx_r + 32'd1;
              hold_v_nxt  = 1'b1;
              state_nxt   = ST_FLUSH;
              if (free_found) begin
                valid_nxt[free_idx] = 1'b1;
                pend_nxt  = pend_r + PW'(1);
                mem_we    = 1'b1;
                mem_waddr = free_idx;
                mem_wdata = {next_id_r, 8'd0};
                hold_nxt  = '{kind: umrt_pkg::KIND_SENT, slot: 4'(free_idx),
                              msg_id: next_id_r, tx: tx_r + 32'd1,
                              pend: 5'(pend_r + PW'(1))};
              end else begin
                hold_nxt  = '{kind: umrt_pkg::KIND_DROPPED, slot: 4'd0,
                              msg_id: next_id_r, tx: tx_r + 32'd1, pend: 5'(pend_r)};
              end
            end
            umrt_pkg::OP_ACK: begin
              ack_id_nxt = in_tdata;
              rd_en      = 1'b1;
              idx_nxt    = '0;
              state_nxt  = ST_ACK;
            end
            umrt_pkg::OP_TICK: begin
              if (phase_inc >= interval_eff) begin
                phase_nxt = 8'd0;
                scan_nxt  = 1'b1;
              end else begin
                phase_nxt = phase_inc[7:0];
                scan_nxt  = 1'b0;
              end
              rd_en     = 1'b1;
              idx_nxt   = '0;
              state_nxt = ST_TICK;
            end
            default: begin
              // unused opcode: dropped without effect
            end
          endcase
        end
      end

      ST_ACK: begin
        // hold is empty here, an ack gives exactly one result
        if (ack_hit) begin
          valid_nxt[idx_r] = 1'b0;
          pend_nxt   = pend_r - PW'(1);
          hold_v_nxt = 1'b1;
          hold_nxt   = '{kind: umrt_pkg::KIND_ACKED, slot: 4'(idx_r), msg_id: ack_id_r,
                         tx: tx_r, pend: 5'(pend_r - PW'(1))};
          state_nxt  = ST_FLUSH;
        end else if (idx_r == LAST_IDX) begin
          hold_v_nxt = 1'b1;
          hold_nxt   = '{kind: umrt_pkg::KIND_NO_ACK, slot: 4'd0, msg_id: ack_id_r,
                         tx: tx_r, pend: 5'(pend_r)};
          state_nxt  = ST_FLUSH;
        end else begin
          idx_nxt = idx_r + IW'(1);
          rd_en   = 1'b1;
          rd_addr = idx_r + IW'(1);
        end
      end

      ST_TICK: begin
        // a retransmit waits while the previous one cannot leave the hold register;
        // rdata_r keeps the current slot because no read is issued meanwhile
        if (!(tick_hit && hold_v_r && !out_free)) begin
          if (cur_valid) begin
            mem_we    = 1'b1;
            mem_waddr = idx_r;
            mem_wdata = {rd_id, tick_hit ? 8'd0 : age_inc};
          end
          if (tick_hit) begin
            tx_nxt     = tx_r + 32'd1;
            out_load   = hold_v_r;
            hold_v_nxt = 1'b1;
            hold_nxt   = '{kind: umrt_pkg::KIND_RETX, slot: 4'(idx_r), msg_id: rd_id,
                           tx: tx_r + 32'd1, pend: 5'(pend_r)};
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + IW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + IW'(1);
          end
        end
      end

      ST_FLUSH: begin
        // the held result is the final one of the transaction
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load      = 1'b1;
          out_load_last = 1'b1;
          hold_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_v_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_v_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      idx_r      <= '0;
      valid_r    <= '0;
      pend_r     <= '0;
      next_id_r  <= '0;
      tx_r       <= '0;
      phase_r    <= '0;
      scan_r     <= 1'b0;
      hold_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
      timeout_r  <= 8'd2;
      interval_r <= 8'd1;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      valid_r   <= valid_nxt;
      pend_r    <= pend_nxt;
      next_id_r <= next_id_nxt;
      tx_r      <= tx_nxt;
      phase_r   <= phase_nxt;
      scan_r    <= scan_nxt;
      hold_v_r  <= hold_v_nxt;
      out_v_r   <= out_v_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          umrt_pkg::CFG_TIMEOUT:  timeout_r  <= cfg_data;
          umrt_pkg::CFG_INTERVAL: interval_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ack_id_r <= ack_id_nxt;
    hold_r   <= hold_nxt;
    if (out_load) begin
      out_r      <= hold_r;
      out_last_r <= out_load_last;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_r.pend, out_r.tx, out_r.msg_id, out_r.slot};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_last_r;

  // occupancy counter tracks the valid bits
  a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == PW'($countones(valid_r)))
    else $error("pending count differs from valid bits");

  // nothing left in the hold register once the sequencer is idle
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !hold_v_r)
    else $error("held result left behind at idle");

  // a send always produces a held result in the following cycle
  a_send_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == umrt_pkg::OP_SEND) |=>
      (hold_v_r && state_r == ST_FLUSH))
    else $error("send transaction produced no result");

endmodule

`default_nettype wire

@@ tb/unacked_message_retransmit_table_tb.sv @@
// unacked_message_retransmit_table_tb: self-checking bench for the retransmit slot table,
// a behavioural copy of the table predicts every result and a monitor compares them
// depends on umrt_pkg and unacked_message_retransmit_table
`default_nettype none

module unacked_message_retransmit_table_tb;

  localparam int SLOTS = 16;
  // opcode three has no meaning and must be swallowed without a result
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // room for the slot-by-slot scan of a tick after the last result
  localparam int SETTLE_CYCLES = SLOTS + 6;

  // one expected result transaction
  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [15:0] msg_id;
    logic [31:0] tx;
    logic [4:0]  pend;
    logic        last;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // [15:0] ack_id
  logic [1:0]  in_tuser = '0;    // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;        // [3:0] slot, [19:4] message_id, [51:20] transmissions,
                                 // [56:52] pending
  logic [2:0]  out_tuser;        // [2:0] kind
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;

  // behavioural copy of the table, reset values
  logic        tbl_valid [SLOTS];
  logic [15:0] tbl_id [SLOTS];
  logic [7:0]  tbl_age [SLOTS];
  logic [15:0] id_counter = '0;
  logic [31:0] tx_total = '0;
  int          scan_count = 0;
  logic [7:0]  cfg_timeout = 8'd2;
  logic [7:0]  cfg_interval = 8'd1;

  outcome_t    expected_results[$];
  outcome_t    seen;
  int          mismatches = 0;
  bit          no_gaps = 1'b0;   // both sides run flat out while set
  int          hold_left = 0;    // receiver hold-off, counted down by the receiver

  unacked_message_retransmit_table #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_id[i] = '0;
      tbl_age[i] = '0;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int occupied_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i]) n++;
    return n;
  endfunction

  task automatic queue_result(input logic [2:0] kind, input int slot, input logic [15:0] id);
    outcome_t r;
    r.kind = kind;
    r.slot = slot[3:0];
    r.msg_id = id;
    r.tx = tx_total;
    r.pend = 5'(occupied_slots());
    r.last = 1'b0;
    expected_results.push_back(r);
  endtask

  // apply one accepted event to the table copy and queue what it emits
  task automatic predict_table_results(input logic [1:0] op, input logic [15:0] aid);
    int        before_n;
    int        pick;
    int        interval;
    logic [15:0] new_id;
    outcome_t  tail;
    before_n = expected_results.size();
    pick = -1;
    case (op)
      umrt_pkg::OP_SEND: begin
        // the id and the transmission are spent even when the table is full
        new_id = id_counter;
        id_counter++;
        tx_total++;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!tbl_valid[i]) pick = i;
        if (pick >= 0) begin
          tbl_valid[pick] = 1'b1;
          tbl_id[pick] = new_id;
          tbl_age[pick] = '0;
          queue_result(umrt_pkg::KIND_SENT, pick, new_id);
        end else begin
          queue_result(umrt_pkg::KIND_DROPPED, 0, new_id);
        end
      end
      umrt_pkg::OP_ACK: begin
        // lowest matching slot wins when an id is held twice
        for (int i = SLOTS - 1; i >= 0; i--)
          if (tbl_valid[i] && tbl_id[i] == aid) pick = i;
        if (pick >= 0) begin
          tbl_valid[pick] = 1'b0;
          queue_result(umrt_pkg::KIND_ACKED, pick, aid);
        end else begin
          queue_result(umrt_pkg::KIND_NO_ACK, 0, aid);
        end
      end
      umrt_pkg::OP_TICK: begin
        for (int i = 0; i < SLOTS; i++)
          if (tbl_valid[i] && tbl_age[i] != umrt_pkg::AGE_MAX) tbl_age[i]++;
        // an interval of zero behaves as one
        interval = (cfg_interval == 0) ? 1 : int'(cfg_interval);
        if (scan_count + 1 >= interval) begin
          scan_count = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (tbl_valid[i] && tbl_age[i] > cfg_timeout) begin
              tbl_age[i] = '0;
              tx_total++;
              queue_result(umrt_pkg::KIND_RETX, i, tbl_id[i]);
            end
          end
        end else begin
          scan_count++;
        end
      end
      default: ;
    endcase
    if (expected_results.size() > before_n) begin
      tail = expected_results.pop_back();
      tail.last = 1'b1;
      expected_results.push_back(tail);
    end
  endtask

  // id of a random occupied slot, or any id when the table is empty
  function automatic logic [15:0] pick_live_id();
    int live[$];
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i]) live.push_back(i);
    if (live.size() == 0) return 16'($urandom_range(0, 16'hFFFF));
    return tbl_id[live[$urandom_range(0, live.size() - 1)]];
  endfunction

  // ---------------------------------------------------------------- drivers

  // offers one event, returns at the edge where the transaction is taken;
  // tvalid stays high so back-to-back events need no extra edge
  task automatic send_event(input logic [1:0] op, input logic [15:0] aid);
    int gap;
    gap = 0;
    if (!no_gaps)
      while ($urandom_range(0, 99) < 29) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= aid;
    do @(posedge clk); while (!in_tready);
    predict_table_results(op, aid);
  endtask

  task automatic send_random_event();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 35)      send_event(umrt_pkg::OP_SEND, 16'($urandom_range(0, 16'hFFFF)));
    else if (roll < 65) send_event(umrt_pkg::OP_ACK, pick_live_id());
    else if (roll < 75) send_event(umrt_pkg::OP_ACK, 16'($urandom_range(0, 16'hFFFF)));
    else if (roll < 97) send_event(umrt_pkg::OP_TICK, 16'($urandom_range(0, 16'hFFFF)));
    else                send_event(OP_UNUSED, 16'($urandom_range(0, 16'hFFFF)));
  endtask

  // wait for every expected result, then for a silent tick scan to finish
  task automatic drain_table();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == umrt_pkg::CFG_TIMEOUT) cfg_timeout = value;
    else cfg_interval = value;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] timeout, input logic [7:0] interval);
    drain_table();
    write_register(umrt_pkg::CFG_TIMEOUT, timeout);
    write_register(umrt_pkg::CFG_INTERVAL, interval);
  endtask

  // ---------------------------------------------------------------- receiver and monitor

  // random stalls, a counted hold-off when asked, none at all during flat-out stretches
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= no_gaps || ($urandom_range(0, 99) >= 29);
    end
  end

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // every result transaction is matched against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result kind %0d slot %0d id %h",
                               out_tuser, out_tdata[3:0], out_tdata[19:4]));
      end else begin
        seen = expected_results.pop_front();
        if (out_tuser !== seen.kind || out_tdata[3:0] !== seen.slot ||
            out_tdata[19:4] !== seen.msg_id || out_tdata[51:20] !== seen.tx ||
            out_tdata[56:52] !== seen.pend || out_tlast !== seen.last)
          note_failure($sformatf(
            "exp kind %0d slot %0d id %h tx %0d pend %0d last %b, got %0d %0d %h %0d %0d %b",
            seen.kind, seen.slot, seen.msg_id, seen.tx, seen.pend, seen.last,
            out_tuser, out_tdata[3:0], out_tdata[19:4], out_tdata[51:20],
            out_tdata[56:52], out_tlast));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // register defaults: timeout two, scan on every tick
  task automatic test_reset_defaults();
    send_event(umrt_pkg::OP_SEND, 16'hFFFF);
    send_event(umrt_pkg::OP_SEND, 16'h0000);
    send_event(umrt_pkg::OP_TICK, 16'h0000);
    send_event(umrt_pkg::OP_TICK, 16'hFFFF);
    send_event(umrt_pkg::OP_TICK, 16'h5A5A);   // both slots now older than two, retransmitted
    send_event(umrt_pkg::OP_ACK, 16'h0001);
    send_event(umrt_pkg::OP_ACK, 16'hFFFF);    // nothing holds this id
    send_event(OP_UNUSED, 16'hFFFF);           // ignored opcode
    send_event(umrt_pkg::OP_ACK, 16'h0000);
    send_event(umrt_pkg::OP_ACK, 16'h0000);    // already freed
  endtask

  // fill every slot, overflow it, refill a hole from the bottom
  task automatic test_full_table();
    apply_settings(8'd255, 8'd255);
    repeat (SLOTS + 2) send_event(umrt_pkg::OP_SEND, 16'($urandom_range(0, 16'hFFFF)));
    send_event(umrt_pkg::OP_ACK, tbl_id[5]);
    send_event(umrt_pkg::OP_SEND, 16'h0000);   // lands in the freed slot
  endtask

  // ages stick at the top, then scans of a full table
  task automatic test_age_saturation();
    apply_settings(8'd255, 8'd1);    // nothing can exceed this timeout
    repeat (256) send_event(umrt_pkg::OP_TICK, 16'($urandom_range(0, 16'hFFFF)));
    apply_settings(8'd254, 8'd1);
    send_event(umrt_pkg::OP_TICK, 16'h0000);   // every slot retransmitted at once
    apply_settings(8'd0, 8'd0);      // zero interval scans on every tick
    send_event(umrt_pkg::OP_TICK, 16'h0000);
    send_event(umrt_pkg::OP_TICK, 16'h0000);
  endtask

  // receiver holds off while events keep coming, the block must stall its input
  task automatic test_output_backpressure();
    apply_settings(8'd1, 8'd1);
    hold_left = 300;
    repeat (30) send_random_event();
  endtask

  // random traffic over several settings, one stretch flat out
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       apply_settings(8'd0, 8'd1);
        1:       apply_settings(8'd3, 8'd2);
        3:       apply_settings(8'd1, 8'd0);
        default: apply_settings(8'($urandom_range(0, 6)), 8'($urandom_range(0, 4)));
      endcase
      no_gaps = (phase == 3);
      repeat ((phase == 3) ? 28 : 12) send_random_event();
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_full_table();
    test_age_saturation();
    test_output_backpressure();
    test_random_traffic();
    drain_table();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS unacked_message_retransmit_table");
    end else begin
      $display("FAIL unacked_message_retransmit_table");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("FAIL unacked_message_retransmit_table");
    $finish;
  end

endmodule

`default_nettype wire
